>>> hw/rtl/sale_pkg.sv
// ----------------------------------------------------------------------------
// sale_pkg
// Types, command codes and sizes shared by the array list engine and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package sale_pkg;

	localparam int unsigned CAPACITY_DEF = 16;
	localparam int unsigned KEY_W        = 32;
	localparam int unsigned PAY_W        = 32;
	localparam int unsigned CMD_W        = 3;
	localparam int unsigned CNT_OUT_W    = 5;

	localparam logic [CMD_W-1:0] CMD_APPEND       = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT_FRONT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INSERT_SORT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REMOVE_LAST  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_REMOVE_FIRST = 3'd4;
	localparam logic [CMD_W-1:0] CMD_REMOVE_KEY   = 3'd5;

	// Condition under which a cell keeps its entry, given that all cells
	// before it keep theirs.
	typedef enum logic [2:0] {
		SEL_HOLD,   // every cell keeps
		SEL_VALID,  // keep while the cell holds an entry
		SEL_NONE,   // no cell keeps
		SEL_LESS,   // keep while the stored key is below the new key
		SEL_NE      // keep while the stored key differs from the given key
	} sel_t;

	typedef struct packed {
		logic                    en;
		logic                    up;
		sel_t                    sel;
		logic signed [KEY_W-1:0] key;
		logic        [PAY_W-1:0] payload;
	} ctrl_t;

	typedef struct packed {
		logic        [CMD_W-1:0] cmd;
		logic signed [KEY_W-1:0] entry_key;
		logic        [PAY_W-1:0] entry_payload;
	} req_t;

	typedef struct packed {
		logic                 ok;
		logic [CNT_OUT_W-1:0] entry_count;
		logic                 is_full;
		logic                 is_empty;
	} rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/static_array_list_engine.sv
// The response is registered at the edge that accepts its command.
// Throughput: one command per cycle while responses drain; all cells compare and
// shift in the same cycle, limited by the hold flag rippling along CAPACITY cells.
// Reset clears the entry count and the response valid flag; stored keys and
// payloads are undefined until written and are never read before that.
// ----------------------------------------------------------------------------
// static_array_list_engine
// Fixed-capacity ordered list of keyed records built as a row of cells.
// ----------------------------------------------------------------------------
`default_nettype none

module static_array_list_engine #(
	parameter int unsigned CAPACITY = sale_pkg::CAPACITY_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire sale_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output sale_pkg::rsp_t      rsp
);

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_nxt;
	logic                 rsp_valid_q;
	sale_pkg::rsp_t       rsp_q;
	sale_pkg::ctrl_t      ctrl;
	logic                 accept;
	logic                 can_ins;
	logic                 can_rem;
	logic                 inc;
	logic                 dec_fixed;
	logic                 is_key_rm;
	logic                 found;
	logic                 ok;

	logic                              hold [CAPACITY+1];
	logic signed [sale_pkg::KEY_W-1:0] cell_key [CAPACITY];
	logic        [sale_pkg::PAY_W-1:0] cell_payload [CAPACITY];

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign can_ins   = count_q < CNT_W'(CAPACITY);
	assign can_rem   = count_q != '0;

	always_comb begin
		ctrl.en      = accept;
		ctrl.up      = 1'b1;
		ctrl.sel     = sale_pkg::SEL_HOLD;
		ctrl.key     = req.entry_key;
		ctrl.payload = req.entry_payload;
		inc          = 1'b0;
		dec_fixed    = 1'b0;
		is_key_rm    = 1'b0;
		case (req.cmd)
			sale_pkg::CMD_APPEND: begin
				ctrl.sel = can_ins ? sale_pkg::SEL_VALID : sale_pkg::SEL_HOLD;
				inc      = can_ins;
			end
			sale_pkg::CMD_INSERT_FRONT: begin
				ctrl.sel = can_ins ? sale_pkg::SEL_NONE : sale_pkg::SEL_HOLD;
				inc      = can_ins;
			end
			sale_pkg::CMD_INSERT_SORT: begin
				ctrl.sel = can_ins ? sale_pkg::SEL_LESS : sale_pkg::SEL_HOLD;
				inc      = can_ins;
			end
			sale_pkg::CMD_REMOVE_LAST: begin
				dec_fixed = can_rem;
			end
			sale_pkg::CMD_REMOVE_FIRST: begin
				ctrl.up   = 1'b0;
				ctrl.sel  = can_rem ? sale_pkg::SEL_NONE : sale_pkg::SEL_HOLD;
				dec_fixed = can_rem;
			end
			sale_pkg::CMD_REMOVE_KEY: begin
				ctrl.up   = 1'b0;
				ctrl.sel  = sale_pkg::SEL_NE;
				is_key_rm = 1'b1;
			end
			default: begin
				ctrl.sel = sale_pkg::SEL_HOLD;
			end
		endcase
	end

	// A match somewhere in the valid part stops the hold flag before the end.
	assign found = !hold[CAPACITY];
	assign ok    = inc || dec_fixed || (is_key_rm && found);

	always_comb begin
		count_nxt = count_q;
		if (inc) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (ok) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	assign hold[0] = 1'b1;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                              valid;
		logic signed [sale_pkg::KEY_W-1:0] l_key;
		logic        [sale_pkg::PAY_W-1:0] l_pay;
		logic signed [sale_pkg::KEY_W-1:0] r_key;
		logic        [sale_pkg::PAY_W-1:0] r_pay;

		assign valid = count_q > CNT_W'(i);

		if (i == 0) begin : g_first
			assign l_key = req.entry_key;
			assign l_pay = req.entry_payload;
		end else begin : g_mid_l
			assign l_key = cell_key[i-1];
			assign l_pay = cell_payload[i-1];
		end

		// The last cell only ever loads from the right once it drops out of the list.
		if (i == CAPACITY - 1) begin : g_last
			assign r_key = cell_key[i];
			assign r_pay = cell_payload[i];
		end else begin : g_mid_r
			assign r_key = cell_key[i+1];
			assign r_pay = cell_payload[i+1];
		end

		sale_cell u_cell (
			.clk           (clk),
			.ctrl          (ctrl),
			.valid         (valid),
			.hold_in       (hold[i]),
			.hold_out      (hold[i+1]),
			.left_key      (l_key),
			.left_payload  (l_pay),
			.right_key     (r_key),
			.right_payload (r_pay),
			.key           (cell_key[i]),
			.payload       (cell_payload[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.ok          <= ok;
			rsp_q.entry_count <= sale_pkg::CNT_OUT_W'(count_nxt);
			rsp_q.is_full     <= count_nxt == CNT_W'(CAPACITY);
			rsp_q.is_empty    <= count_nxt == '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

>>> hw/rtl/sale_cell.sv
// ----------------------------------------------------------------------------
// sale_cell
// One list slot: holds a key and payload, passes a hold flag down the row and
// loads from the new record or from its left or right neighbour.
// ----------------------------------------------------------------------------
`default_nettype none

module sale_cell (
	input  wire logic                            clk,
	input  wire sale_pkg::ctrl_t                 ctrl,
	input  wire logic                            valid,
	input  wire logic                            hold_in,
	output logic                                 hold_out,
	input  wire logic signed [sale_pkg::KEY_W-1:0] left_key,
	input  wire logic        [sale_pkg::PAY_W-1:0] left_payload,
	input  wire logic signed [sale_pkg::KEY_W-1:0] right_key,
	input  wire logic        [sale_pkg::PAY_W-1:0] right_payload,
	output logic signed [sale_pkg::KEY_W-1:0]    key,
	output logic        [sale_pkg::PAY_W-1:0]    payload
);

	logic signed [sale_pkg::KEY_W-1:0] key_q;
	logic        [sale_pkg::PAY_W-1:0] payload_q;
	logic                              keep;

	always_comb begin
		case (ctrl.sel)
			sale_pkg::SEL_HOLD:  keep = 1'b1;
			sale_pkg::SEL_VALID: keep = valid;
			sale_pkg::SEL_NONE:  keep = 1'b0;
			sale_pkg::SEL_LESS:  keep = valid && (key_q < ctrl.key);
			sale_pkg::SEL_NE:    keep = !(valid && (key_q == ctrl.key));
			default:             keep = 1'b1;
		endcase
		hold_out = hold_in && keep;
	end

	// First non-holding cell takes the new record on insert; the rest shift.
	always_ff @(posedge clk) begin
		if (ctrl.en && !hold_out) begin
			if (ctrl.up) begin
				if (hold_in) begin
					key_q     <= ctrl.key;
					payload_q <= ctrl.payload;
				end else begin
					key_q     <= left_key;
					payload_q <= left_payload;
				end
			end else begin
				key_q     <= right_key;
				payload_q <= right_payload;
			end
		end
	end

	assign key     = key_q;
	assign payload = payload_q;

endmodule

`default_nettype wire

>>> hw/rtl/sale_checker.sv
// ----------------------------------------------------------------------------
// sale_checker
// Port-level checks on the array list engine, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sale_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_ready,
	input wire sale_pkg::req_t req,
	input wire logic           rsp_valid,
	input wire logic           rsp_ready,
	input wire sale_pkg::rsp_t rsp
);

	// Every accepted command yields a response in the next cycle.
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> rsp_valid)
		else $error("no response after accepted command");

	// A stalled response holds its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled response changed");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.is_empty == (rsp.entry_count == '0)))
		else $error("empty flag disagrees with count");

	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.is_full && rsp.is_empty))
		else $error("list reported both full and empty");

	// A back-to-back response moves the count by at most one.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_ready && req_valid && req_ready) |=>
		((rsp.entry_count == $past(rsp.entry_count)) ||
		 (rsp.entry_count == $past(rsp.entry_count) + 5'd1) ||
		 (rsp.entry_count == $past(rsp.entry_count) - 5'd1)))
		else $error("count moved by more than one");

endmodule

bind static_array_list_engine sale_checker u_sale_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for static_array_list_engine. A short table of commands
// covers empty and full lists, equal keys, absent keys and unknown codes; a
// long random run then follows, swinging the list between empty and full.
// Responses are checked against the table row or the bench's behavioural list.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP        = int'(sale_pkg::CAPACITY_DEF);
	localparam int N_RAND     = 1620;
	localparam int SQUEEZE_AT = 1200;
	localparam int SQUEEZE_LEN = 90;

	localparam sale_pkg::rsp_t NOTHING_TO_REMOVE = '{ok: 1'b0, entry_count: 5'd0,
		is_full: 1'b0, is_empty: 1'b1};
	localparam sale_pkg::rsp_t NO_ROOM = '{ok: 1'b0,
		entry_count: sale_pkg::CNT_OUT_W'(CAP), is_full: 1'b1, is_empty: 1'b0};

	typedef struct {
		sale_pkg::req_t item;
		int             rep;
		bit             typed;
		sale_pkg::rsp_t want;
	} dir_row_t;

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_ready;
	sale_pkg::req_t req;
	logic           rsp_valid;
	logic           rsp_ready;
	sale_pkg::rsp_t rsp;

	// behavioural copy of the list
	logic signed [sale_pkg::KEY_W-1:0] lst_key [CAP];
	logic        [sale_pkg::PAY_W-1:0] lst_pay [CAP];
	int                                lst_len;

	sale_pkg::rsp_t pending_status [$];
	dir_row_t       dir_rows [$];
	int             bad_count;
	int             cmds_taken;
	int             phase;
	int             send_pct [3] = '{29, 49, 0};
	int             recv_pct [3] = '{49, 29, 0};

	static_array_list_engine u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Apply one command to the list and return the status it reports.
	function automatic sale_pkg::rsp_t list_apply(sale_pkg::req_t r);
		sale_pkg::rsp_t                    s;
		logic signed [sale_pkg::KEY_W-1:0] k;
		int                                pos;
		bit                                ok;
		k   = r.entry_key;
		pos = 0;
		ok  = 1'b0;
		case (r.cmd)
			sale_pkg::CMD_APPEND, sale_pkg::CMD_INSERT_FRONT,
			sale_pkg::CMD_INSERT_SORT: begin
				if (lst_len < CAP) begin
					if (r.cmd == sale_pkg::CMD_APPEND)
						pos = lst_len;
					else if (r.cmd == sale_pkg::CMD_INSERT_SORT)
						while (pos < lst_len && $signed(lst_key[pos]) < $signed(k))
							pos++;
					for (int i = lst_len; i > pos; i--) begin
						lst_key[i] = lst_key[i-1];
						lst_pay[i] = lst_pay[i-1];
					end
					lst_key[pos] = k;
					lst_pay[pos] = r.entry_payload;
					lst_len++;
					ok = 1'b1;
				end
			end
			sale_pkg::CMD_REMOVE_LAST, sale_pkg::CMD_REMOVE_FIRST,
			sale_pkg::CMD_REMOVE_KEY: begin
				if (lst_len > 0) begin
					if (r.cmd == sale_pkg::CMD_REMOVE_KEY)
						while (pos < lst_len && lst_key[pos] != k)
							pos++;
					ok = (r.cmd != sale_pkg::CMD_REMOVE_KEY) || (pos < lst_len);
					if (ok && r.cmd != sale_pkg::CMD_REMOVE_LAST)
						for (int i = pos; i + 1 < lst_len; i++) begin
							lst_key[i] = lst_key[i+1];
							lst_pay[i] = lst_pay[i+1];
						end
					if (ok)
						lst_len--;
				end
			end
			default: ;
		endcase
		s.ok          = ok;
		s.entry_count = lst_len[sale_pkg::CNT_OUT_W-1:0];
		s.is_full     = (lst_len == CAP);
		s.is_empty    = (lst_len == 0);
		return s;
	endfunction

	// Keys cluster on extremes and a few small values so that equal keys turn up.
	function automatic logic signed [sale_pkg::KEY_W-1:0] pick_key();
		case ($urandom_range(0, 9))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return '0;
			3:       return -1;
			4, 5:    return $signed($urandom_range(0, 7)) - 3;
			default: return $urandom;
		endcase
	endfunction

	// Alternate between filling and draining the list every 40 commands.
	function automatic sale_pkg::req_t draw_cmd();
		sale_pkg::req_t r;
		int             roll;
		bit             filling;
		r.entry_key     = pick_key();
		r.entry_payload = $urandom;
		roll            = $urandom_range(0, 99);
		filling         = ((cmds_taken / 40) % 2) == 0;
		if (roll < 3)
			r.cmd = sale_pkg::CMD_REMOVE_KEY + sale_pkg::CMD_W'($urandom_range(1, 2));
		else if (filling ? roll < 70 : roll < 30)
			r.cmd = sale_pkg::CMD_APPEND + sale_pkg::CMD_W'($urandom_range(0, 2));
		else
			r.cmd = sale_pkg::CMD_REMOVE_LAST + sale_pkg::CMD_W'($urandom_range(0, 2));
		if (r.cmd == sale_pkg::CMD_REMOVE_KEY && lst_len > 0 && $urandom_range(0, 9) < 7)
			r.entry_key = lst_key[$urandom_range(0, lst_len - 1)];
		return r;
	endfunction

	task automatic flag(string what, int want, int got);
		bad_count++;
		if (bad_count <= 10)
			$display("mismatch: %s expected %0d got %0d", what, want, got);
	endtask

	task automatic add_row(logic [sale_pkg::CMD_W-1:0] c,
		logic signed [sale_pkg::KEY_W-1:0] k, logic [sale_pkg::PAY_W-1:0] p,
		int rep, bit typed, sale_pkg::rsp_t want);
		dir_row_t row;
		row.item  = '{cmd: c, entry_key: k, entry_payload: p};
		row.rep   = rep;
		row.typed = typed;
		row.want  = want;
		dir_rows.push_back(row);
	endtask

	// Present one command, hold it until the transfer, then record its status.
	task automatic offer(sale_pkg::req_t item, bit typed, sale_pkg::rsp_t want);
		sale_pkg::rsp_t got;
		while ($urandom_range(0, 99) < send_pct[phase]) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!req_ready);
		got = list_apply(item);
		pending_status.push_back(typed ? want : got);
		cmds_taken++;
	endtask

	// receiver: random stalls, plus one long hold-off to back the block up
	initial begin
		int hold;
		bit squeezed;
		hold      = 0;
		squeezed  = 1'b0;
		rsp_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!squeezed && cmds_taken >= SQUEEZE_AT) begin
				squeezed = 1'b1;
				hold     = SQUEEZE_LEN;
			end
			if (hold > 0) begin
				hold--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(0, 99) >= recv_pct[phase]);
			end
		end
	end

	// response checker
	initial begin
		sale_pkg::rsp_t want;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && rsp_ready) begin
				if (pending_status.size() == 0) begin
					flag("response with none pending", 0, int'(rsp));
				end else begin
					want = pending_status.pop_front();
					if (rsp.ok !== want.ok)
						flag("ok", int'(want.ok), int'(rsp.ok));
					if (rsp.entry_count !== want.entry_count)
						flag("entry_count", int'(want.entry_count), int'(rsp.entry_count));
					if (rsp.is_full !== want.is_full)
						flag("is_full", int'(want.is_full), int'(rsp.is_full));
					if (rsp.is_empty !== want.is_empty)
						flag("is_empty", int'(want.is_empty), int'(rsp.is_empty));
				end
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		req        = '0;
		lst_len    = 0;
		bad_count  = 0;
		cmds_taken = 0;
		phase      = 0;

		// empty list, unknown code, extremes, equal and absent keys, then full
		add_row(sale_pkg::CMD_REMOVE_LAST,  0, 0, 1, 1'b1, NOTHING_TO_REMOVE);
		add_row(sale_pkg::CMD_REMOVE_FIRST, 0, 0, 1, 1'b1, NOTHING_TO_REMOVE);
		add_row(sale_pkg::CMD_REMOVE_KEY,   0, 0, 1, 1'b1, NOTHING_TO_REMOVE);
		add_row(sale_pkg::CMD_REMOVE_KEY + sale_pkg::CMD_W'(1), 0, 0, 1, 1'b1,
			NOTHING_TO_REMOVE);
		add_row(sale_pkg::CMD_APPEND, 32'sh8000_0000, 32'hffff_ffff, 1, 1'b1,
			'{ok: 1'b1, entry_count: 5'd1, is_full: 1'b0, is_empty: 1'b0});
		add_row(sale_pkg::CMD_INSERT_FRONT, 32'sh7fff_ffff, 32'h0, 1, 1'b1,
			'{ok: 1'b1, entry_count: 5'd2, is_full: 1'b0, is_empty: 1'b0});
		add_row(sale_pkg::CMD_INSERT_SORT,  0, 32'h1, 1, 1'b0, '0);
		add_row(sale_pkg::CMD_INSERT_SORT,  0, 32'h2, 1, 1'b0, '0);
		add_row(sale_pkg::CMD_REMOVE_KEY,   5, 0, 1, 1'b0, '0);
		add_row(sale_pkg::CMD_REMOVE_KEY,   0, 0, 1, 1'b0, '0);
		add_row(sale_pkg::CMD_REMOVE_KEY + sale_pkg::CMD_W'(2), 0, 0, 1, 1'b0, '0);
		add_row(sale_pkg::CMD_REMOVE_FIRST, 0, 0, 1, 1'b0, '0);
		add_row(sale_pkg::CMD_REMOVE_LAST,  0, 0, 1, 1'b0, '0);
		add_row(sale_pkg::CMD_APPEND,      -1, 32'h5a5a_a5a5, CAP - 1, 1'b0, '0);
		add_row(sale_pkg::CMD_APPEND,       7, 0, 1, 1'b1, NO_ROOM);
		add_row(sale_pkg::CMD_INSERT_FRONT, 7, 0, 1, 1'b1, NO_ROOM);
		add_row(sale_pkg::CMD_INSERT_SORT,  7, 0, 1, 1'b1, NO_ROOM);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			for (int n = 0; n < dir_rows[i].rep; n++)
				offer(dir_rows[i].item, dir_rows[i].typed && dir_rows[i].rep == 1,
					dir_rows[i].want);

		for (int n = 0; n < N_RAND; n++) begin
			phase = n * 3 / N_RAND;
			offer(draw_cmd(), 1'b0, '0);
		end
		req_valid <= 1'b0;

		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (bad_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/sale_pkg.sv
hw/rtl/sale_cell.sv
hw/rtl/static_array_list_engine.sv
hw/rtl/sale_checker.sv
tb/tb.sv
